### rtl/jtl_pkg.sv
// Shared types and constants of the JSON token lexer.
package jtl_pkg;

	// Input word: one character or an end-of-input mark
	typedef struct packed {
		logic       kind;
		logic [7:0] byte_req;
	} lex_in_t;

	// Output word: one token
	typedef struct packed {
		logic [3:0]  token_kind;
		logic [15:0] line_number;
		logic [6:0]  token_length;
		logic        last;
	} token_t;

	// Tokens handed from the scanner to the output queue in one cycle
	typedef struct packed {
		logic   push0;
		logic   push1;
		token_t tok0;
		token_t tok1;
	} scan_push_t;

	localparam int LINE_OUT_W = 16;
	localparam int TLEN_OUT_W = 7;

	// Input kinds
	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_END  = 1'b1;

	// Token kinds
	localparam logic [3:0] TK_LBRACK = 4'd0;
	localparam logic [3:0] TK_RBRACK = 4'd1;
	localparam logic [3:0] TK_LBRACE = 4'd2;
	localparam logic [3:0] TK_RBRACE = 4'd3;
	localparam logic [3:0] TK_COMMA  = 4'd4;
	localparam logic [3:0] TK_COLON  = 4'd5;
	localparam logic [3:0] TK_STRING = 4'd6;
	localparam logic [3:0] TK_NUMBER = 4'd7;
	localparam logic [3:0] TK_TRUE   = 4'd8;
	localparam logic [3:0] TK_FALSE  = 4'd9;
	localparam logic [3:0] TK_NULL   = 4'd10;
	localparam logic [3:0] TK_END    = 4'd11;
	localparam logic [3:0] TK_ERROR  = 4'd12;

	// Characters
	localparam logic [7:0] CH_LBRACK = "[";
	localparam logic [7:0] CH_RBRACK = "]";
	localparam logic [7:0] CH_LBRACE = "{";
	localparam logic [7:0] CH_RBRACE = "}";
	localparam logic [7:0] CH_COMMA  = ",";
	localparam logic [7:0] CH_COLON  = ":";
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_NL     = 8'h0a;
	localparam logic [7:0] CH_DOT    = ".";
	localparam logic [7:0] CH_PLUS   = "+";
	localparam logic [7:0] CH_MINUS  = "-";
	localparam logic [7:0] CH_LC_E   = "e";
	localparam logic [7:0] CH_UC_E   = "E";

	// Keyword spellings, padded with zeros
	localparam int KW_NUM = 6;
	localparam logic [7:0] KW_TEXT [KW_NUM][8] = '{
		'{"t", "r", "u", "e", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"T", "R", "U", "E", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"f", "a", "l", "s", "e",   8'h00, 8'h00, 8'h00},
		'{"F", "A", "L", "S", "E",   8'h00, 8'h00, 8'h00},
		'{"n", "u", "l", "l", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"N", "U", "L", "L", 8'h00, 8'h00, 8'h00, 8'h00}
	};
	localparam logic [2:0] KW_LEN [KW_NUM] = '{3'd4, 3'd4, 3'd5, 3'd5, 3'd4, 3'd4};
	localparam logic [3:0] KW_TOKEN [KW_NUM] =
		'{TK_TRUE, TK_TRUE, TK_FALSE, TK_FALSE, TK_NULL, TK_NULL};

	// Output queue
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

endpackage

### rtl/jtl_scan.sv
// Lexer state and per-character scan logic.
module jtl_scan import jtl_pkg::*; #(
	parameter int MAX_TOKEN_LEN = 64,
	parameter int LINE_BITS     = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  lex_in_t    word,
	output scan_push_t push
);

	localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1);

	typedef enum logic [3:0] {
		M_IDLE, M_STR, M_WORD, M_INT, M_DOT, M_FRAC, M_E, M_SIGN, M_EXP, M_HALT
	} mode_t;

	mode_t                mode_q, mode_d;
	logic [KW_NUM-1:0]    cand_q, cand_d;
	logic [LEN_W-1:0]     len_q, len_d;
	logic [LINE_BITS-1:0] line_q, line_d;

	logic             fin_v, lex_idle, end_tok, err_tok, str_v, id_v, kw_v, sec_v;
	logic [3:0]       fin_kind, id_kind, kw_kind, sec_kind;
	logic [LEN_W-1:0] fin_len, str_len, sec_len;
	logic [7:0]       c;
	logic             is_dig, is_let, is_e, is_sign;
	token_t           fin_tok, sec_tok;

	function automatic logic [LEN_W-1:0] bump(input logic [LEN_W-1:0] l,
			input logic [1:0] amt);
		logic [LEN_W:0] s;
		s = {1'b0, l} + (LEN_W+1)'(amt);
		if (s > (LEN_W+1)'(MAX_TOKEN_LEN))
			s = (LEN_W+1)'(MAX_TOKEN_LEN);
		return s[LEN_W-1:0];
	endfunction

	// drop spellings that cannot match character ch at position pos
	function automatic logic [KW_NUM-1:0] kw_filter(input logic [KW_NUM-1:0] cand,
			input logic [LEN_W-1:0] pos, input logic [7:0] ch);
		logic [KW_NUM-1:0] r;
		r = cand;
		for (int k = 0; k < KW_NUM; k++) begin
			if (pos >= LEN_W'(KW_LEN[k]) || KW_TEXT[k][pos[2:0]] != ch)
				r[k] = 1'b0;
		end
		return r;
	endfunction

	assign c       = word.byte_req;
	assign is_dig  = (c >= "0") && (c <= "9");
	assign is_let  = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
	assign is_e    = (c == CH_LC_E) || (c == CH_UC_E);
	assign is_sign = (c == CH_PLUS) || (c == CH_MINUS);
	assign str_len = bump(len_q, 2'd1);

	// keyword that a finished word spells, first spelling wins
	always_comb begin
		kw_v    = 1'b0;
		kw_kind = TK_TRUE;
		for (int k = 0; k < KW_NUM; k++) begin
			if (!kw_v && cand_q[k] && len_q == LEN_W'(KW_LEN[k])) begin
				kw_v    = 1'b1;
				kw_kind = KW_TOKEN[k];
			end
		end
	end

	always_comb begin
		mode_d   = mode_q;
		cand_d   = cand_q;
		len_d    = len_q;
		line_d   = line_q;
		fin_v    = 1'b0;
		fin_kind = TK_NUMBER;
		fin_len  = len_q;
		lex_idle = 1'b0;
		end_tok  = 1'b0;
		err_tok  = 1'b0;
		str_v    = 1'b0;
		id_v     = 1'b0;
		id_kind  = TK_LBRACK;
		if (step && mode_q != M_HALT) begin
			if (word.kind == KIND_END) begin
				unique case (mode_q) inside
					M_WORD: begin
						fin_v    = kw_v;
						fin_kind = kw_kind;
					end
					M_INT, M_FRAC, M_EXP: fin_v = 1'b1;
					M_IDLE: ;
					default: err_tok = 1'b1;
				endcase
				if (!err_tok) begin
					end_tok = 1'b1;
					mode_d  = M_IDLE;
					cand_d  = '0;
					len_d   = '0;
					line_d  = LINE_BITS'(1);
				end
			end else begin
				unique case (mode_q) inside
					M_STR: begin
						len_d = str_len;
						if (c == CH_QUOTE) begin
							str_v  = 1'b1;
							mode_d = M_IDLE;
							len_d  = '0;
						end
					end
					M_WORD: begin
						if (is_let || is_dig) begin
							cand_d = kw_filter(cand_q, len_q, c);
							len_d  = bump(len_q, 2'd1);
						end else begin
							fin_v    = kw_v;
							fin_kind = kw_kind;
							cand_d   = '0;
							lex_idle = 1'b1;
						end
					end
					M_INT, M_FRAC: begin
						if (is_dig)
							len_d = bump(len_q, 2'd1);
						else if (c == CH_DOT && mode_q == M_INT)
							mode_d = M_DOT;
						else if (is_e) begin
							len_d  = bump(len_q, 2'd1);
							mode_d = M_E;
						end else begin
							fin_v    = 1'b1;
							lex_idle = 1'b1;
						end
					end
					M_DOT: begin
						if (is_dig) begin
							len_d  = bump(len_q, 2'd2);
							mode_d = M_FRAC;
						end else if (c == CH_DOT) begin
							fin_v    = 1'b1;
							lex_idle = 1'b1;
						end else
							err_tok = 1'b1;
					end
					M_E: begin
						if (is_sign) begin
							len_d  = bump(len_q, 2'd1);
							mode_d = M_SIGN;
						end else if (is_dig) begin
							len_d  = bump(len_q, 2'd1);
							mode_d = M_EXP;
						end else
							err_tok = 1'b1;
					end
					M_SIGN: begin
						if (is_dig) begin
							len_d  = bump(len_q, 2'd1);
							mode_d = M_EXP;
						end else
							err_tok = 1'b1;
					end
					M_EXP: begin
						if (is_dig)
							len_d = bump(len_q, 2'd1);
						else begin
							fin_v    = 1'b1;
							lex_idle = 1'b1;
						end
					end
					default: lex_idle = 1'b1;
				endcase
			end
			// between tokens: punctuation, newline, or start of a lexeme
			if (lex_idle) begin
				mode_d = M_IDLE;
				len_d  = '0;
				if (c == CH_NL) begin
					if (line_q != '1)
						line_d = line_q + 1'b1;
				end else if (c == CH_LBRACK) begin
					id_v = 1'b1; id_kind = TK_LBRACK;
				end else if (c == CH_RBRACK) begin
					id_v = 1'b1; id_kind = TK_RBRACK;
				end else if (c == CH_LBRACE) begin
					id_v = 1'b1; id_kind = TK_LBRACE;
				end else if (c == CH_RBRACE) begin
					id_v = 1'b1; id_kind = TK_RBRACE;
				end else if (c == CH_COMMA) begin
					id_v = 1'b1; id_kind = TK_COMMA;
				end else if (c == CH_COLON) begin
					id_v = 1'b1; id_kind = TK_COLON;
				end else if (c == CH_QUOTE) begin
					mode_d = M_STR;
					len_d  = LEN_W'(1);
				end else if (is_let) begin
					mode_d = M_WORD;
					cand_d = kw_filter('1, '0, c);
					len_d  = LEN_W'(1);
				end else if (is_dig) begin
					mode_d = M_INT;
					len_d  = LEN_W'(1);
				end
			end
			if (err_tok) begin
				mode_d = M_HALT;
				cand_d = '0;
				len_d  = '0;
			end
		end
	end

	// second token of the step: punctuation, string, end or error
	always_comb begin
		sec_v = (lex_idle && id_v) || str_v || end_tok || err_tok;
		if (err_tok) begin
			sec_kind = TK_ERROR;
			sec_len  = '0;
		end else if (end_tok) begin
			sec_kind = TK_END;
			sec_len  = '0;
		end else if (str_v) begin
			sec_kind = TK_STRING;
			sec_len  = str_len;
		end else begin
			sec_kind = id_kind;
			sec_len  = LEN_W'(1);
		end
		fin_tok.token_kind   = fin_kind;
		fin_tok.line_number  = LINE_OUT_W'(line_q);
		fin_tok.token_length = TLEN_OUT_W'(fin_len);
		fin_tok.last         = !sec_v;
		sec_tok.token_kind   = sec_kind;
		sec_tok.line_number  = LINE_OUT_W'(line_q);
		sec_tok.token_length = TLEN_OUT_W'(sec_len);
		sec_tok.last         = 1'b1;
		push.push0 = fin_v || sec_v;
		push.push1 = fin_v && sec_v;
		push.tok0  = fin_v ? fin_tok : sec_tok;
		push.tok1  = sec_tok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			cand_q <= '0;
			len_q  <= '0;
			line_q <= LINE_BITS'(1);
		end else begin
			mode_q <= mode_d;
			cand_q <= cand_d;
			len_q  <= len_d;
			line_q <= line_d;
		end
	end

endmodule

### rtl/jtl_out_fifo.sv
// Output token queue: takes up to two tokens a cycle, gives one while tok_stall is low.
module jtl_out_fifo import jtl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  scan_push_t push,
	output logic       room,
	output logic       tok_valid,
	input  logic       tok_stall,
	output token_t     tok_word
);

	token_t                mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;
	logic                  pop;
	logic [FIFO_PTR_W-1:0] wr_ptr_p1;

	assign tok_valid = (count_q != '0);
	assign tok_word  = mem_q[rd_ptr_q];
	assign pop       = tok_valid && !tok_stall;
	// space for two more even if nothing leaves
	assign room      = (count_q <= FIFO_CNT_W'(FIFO_DEPTH - 2));
	assign wr_ptr_p1 = wr_ptr_q + 1'b1;

	always_ff @(posedge clk) begin
		if (push.push0)
			mem_q[wr_ptr_q] <= push.tok0;
		if (push.push1)
			mem_q[wr_ptr_p1] <= push.tok1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(push.push0) + FIFO_PTR_W'(push.push1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + FIFO_CNT_W'(push.push0) + FIFO_CNT_W'(push.push1)
				- FIFO_CNT_W'(pop);
		end
	end

endmodule

### rtl/json_token_lexer.sv
// Streaming JSON lexer: one character word in, token words out.
//
// Input channel (char_valid / char_stall / char_word): one ASCII character or an
// end-of-input mark per word. Output channel (tok_valid / tok_stall / tok_word):
// one token per word with its kind, line, saturated length and a last flag on
// the final token that an input word caused.
// A taken word waits in the input register until the queue has room; then it is
// lexed and its tokens are written into the output queue, which offers them on
// tok_word from its registers.
// Throughput: one character per cycle while char_stall is low. A character
// that closes a number or word and is itself a token yields two tokens, which
// leave one per cycle while tok_stall is low and hold still while it is high.
// Tokens wait in a four-deep queue; the input register only moves on while the
// queue has room for two; a stalled receiver fills it, then char_stall rises.
// After a syntax error an error token goes out and all later input is taken
// and dropped until reset. End of input flushes a pending token, sends an end
// token and returns to the start state with the line count back at one.
// Reset (arst_n low) empties the queue and the input register and puts the
// scanner between tokens on line one; no warm-up cycles are needed.
module json_token_lexer import jtl_pkg::*; #(
	parameter int MAX_TOKEN_LEN = 64,
	parameter int LINE_BITS     = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    char_valid,
	output logic    char_stall,
	input  lex_in_t char_word,
	output logic    tok_valid,
	input  logic    tok_stall,
	output token_t  tok_word
);

	lex_in_t    word_s1;
	logic       valid_s1;
	logic       room;
	logic       step;
	scan_push_t push;

	// the held word is lexed once the queue can absorb two tokens
	assign step       = valid_s1 && room;
	assign char_stall = valid_s1 && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (!char_stall)
			valid_s1 <= char_valid;
	end

	always_ff @(posedge clk) begin
		if (char_valid && !char_stall)
			word_s1 <= char_word;
	end

	jtl_scan #(
		.MAX_TOKEN_LEN (MAX_TOKEN_LEN),
		.LINE_BITS     (LINE_BITS)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.word   (word_s1),
		.push   (push)
	);

	jtl_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.tok_valid (tok_valid),
		.tok_stall (tok_stall),
		.tok_word  (tok_word)
	);

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench of the streaming JSON token lexer, with its own token predictor.
module testbench;
	import jtl_pkg::*;

	localparam int MAX_LEN      = 64;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int RANDOM_WORDS = 1350;

	// Scanner states of the predictor
	typedef enum logic [3:0] {
		SM_IDLE, SM_STR, SM_WORD, SM_INT, SM_DOT, SM_FRAC, SM_E, SM_SIGN, SM_EXP, SM_HALT
	} scan_state_t;

	logic    clk = 1'b0;
	logic    arst_n;
	logic    char_valid;
	logic    char_stall;
	lex_in_t char_word;
	logic    tok_valid;
	logic    tok_stall;
	token_t  tok_word;

	// Predictor state
	scan_state_t lx_mode;
	logic [5:0]  lx_cand;
	logic [6:0]  lx_len;
	logic [15:0] lx_line;
	token_t      step_out[$];
	token_t      tokens_due[$];

	int mismatches       = 0;
	int cycles           = 0;
	int words_sent       = 0;
	int burst_left       = 0;
	int hold_off_request = 0;
	bit steady           = 1'b0;

	json_token_lexer uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_word  (char_word),
		.tok_valid  (tok_valid),
		.tok_stall  (tok_stall),
		.tok_word   (tok_word)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Character classes and keyword spellings
	// ---------------------------------------------------------------
	function automatic bit is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit is_letter(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	// Character pos of keyword spelling k; zero past its end
	function automatic logic [7:0] kw_char(input int k, input int pos);
		logic [39:0] spell;
		int          n;
		n = (k == 2 || k == 3) ? 5 : 4;
		case (k)
			0:       spell = 40'("true");
			1:       spell = 40'("TRUE");
			2:       spell = 40'("false");
			3:       spell = 40'("FALSE");
			4:       spell = 40'("null");
			default: spell = 40'("NULL");
		endcase
		if (pos >= n)
			return 8'h00;
		return spell[8 * (n - 1 - pos) +: 8];
	endfunction

	// ---------------------------------------------------------------
	// Token predictor
	// ---------------------------------------------------------------
	task automatic clear_lexer();
		lx_mode = SM_IDLE;
		lx_cand = '0;
		lx_len  = '0;
		lx_line = 16'd1;
	endtask

	task automatic emit(input logic [3:0] kind, input logic [6:0] n);
		token_t t;
		t.token_kind   = kind;
		t.line_number  = lx_line;
		t.token_length = n;
		t.last         = 1'b0;
		step_out.push_back(t);
	endtask

	task automatic bump(input int n);
		int s;
		s = lx_len + n;
		if (s > MAX_LEN)
			s = MAX_LEN;
		lx_len = s[6:0];
	endtask

	// drop every spelling that disagrees at the current position
	task automatic narrow_keywords(input logic [7:0] c);
		int k;
		for (k = 0; k < 6; k++)
			if (kw_char(k, int'(lx_len)) != c)
				lx_cand[k] = 1'b0;
	endtask

	task automatic finish_word();
		int k;
		bit done;
		done = 1'b0;
		for (k = 0; k < 6; k++) begin
			// a surviving spelling matches only if it ends exactly here
			if (!done && lx_cand[k] && kw_char(k, int'(lx_len)) == 8'h00) begin
				case (k / 2)
					0:       emit(TK_TRUE, lx_len);
					1:       emit(TK_FALSE, lx_len);
					default: emit(TK_NULL, lx_len);
				endcase
				done = 1'b1;
			end
		end
		lx_cand = '0;
	endtask

	task automatic halt_lexer();
		emit(TK_ERROR, 7'd0);
		lx_mode = SM_HALT;
		lx_cand = '0;
		lx_len  = '0;
	endtask

	// character seen between tokens
	task automatic lex_between(input logic [7:0] c);
		lx_mode = SM_IDLE;
		lx_len  = '0;
		case (c)
			CH_NL:     if (lx_line != 16'hFFFF) lx_line = lx_line + 16'd1;
			CH_LBRACK: emit(TK_LBRACK, 7'd1);
			CH_RBRACK: emit(TK_RBRACK, 7'd1);
			CH_LBRACE: emit(TK_LBRACE, 7'd1);
			CH_RBRACE: emit(TK_RBRACE, 7'd1);
			CH_COMMA:  emit(TK_COMMA, 7'd1);
			CH_COLON:  emit(TK_COLON, 7'd1);
			CH_QUOTE: begin
				lx_mode = SM_STR;
				lx_len  = 7'd1;
			end
			default: begin
				if (is_letter(c)) begin
					lx_mode = SM_WORD;
					lx_cand = '1;
					narrow_keywords(c);
					lx_len = 7'd1;
				end else if (is_digit(c)) begin
					lx_mode = SM_INT;
					lx_len  = 7'd1;
				end
			end
		endcase
	endtask

	task automatic predict_tokens(input lex_in_t w);
		logic [7:0] c;
		token_t     t;
		c = w.byte_req;
		step_out.delete();
		if (lx_mode != SM_HALT) begin
			if (w.kind == KIND_END) begin
				case (lx_mode)
					SM_IDLE: ;
					SM_WORD: finish_word();
					SM_INT, SM_FRAC, SM_EXP: emit(TK_NUMBER, lx_len);
					default: halt_lexer();
				endcase
				if (lx_mode != SM_HALT) begin
					emit(TK_END, 7'd0);
					clear_lexer();
				end
			end else begin
				case (lx_mode)
					SM_STR: begin
						bump(1);
						if (c == CH_QUOTE) begin
							emit(TK_STRING, lx_len);
							lx_mode = SM_IDLE;
							lx_len  = '0;
						end
					end
					SM_WORD: begin
						if (is_letter(c) || is_digit(c)) begin
							narrow_keywords(c);
							bump(1);
						end else begin
							finish_word();
							lex_between(c);
						end
					end
					SM_INT: begin
						if (is_digit(c))
							bump(1);
						else if (c == CH_DOT)
							lx_mode = SM_DOT;
						else if (c == CH_LC_E || c == CH_UC_E) begin
							bump(1);
							lx_mode = SM_E;
						end else begin
							emit(TK_NUMBER, lx_len);
							lex_between(c);
						end
					end
					SM_DOT: begin
						// the dot is counted only once a digit follows it
						if (is_digit(c)) begin
							bump(2);
							lx_mode = SM_FRAC;
						end else if (c == CH_DOT) begin
							emit(TK_NUMBER, lx_len);
							lex_between(c);
						end else
							halt_lexer();
					end
					SM_FRAC: begin
						if (is_digit(c))
							bump(1);
						else if (c == CH_LC_E || c == CH_UC_E) begin
							bump(1);
							lx_mode = SM_E;
						end else begin
							emit(TK_NUMBER, lx_len);
							lex_between(c);
						end
					end
					SM_E: begin
						if (c == CH_PLUS || c == CH_MINUS) begin
							bump(1);
							lx_mode = SM_SIGN;
						end else if (is_digit(c)) begin
							bump(1);
							lx_mode = SM_EXP;
						end else
							halt_lexer();
					end
					SM_SIGN: begin
						if (is_digit(c)) begin
							bump(1);
							lx_mode = SM_EXP;
						end else
							halt_lexer();
					end
					SM_EXP: begin
						if (is_digit(c))
							bump(1);
						else begin
							emit(TK_NUMBER, lx_len);
							lex_between(c);
						end
					end
					default: lex_between(c);
				endcase
			end
		end
		if (step_out.size() > 0) begin
			t = step_out.pop_back();
			t.last = 1'b1;
			step_out.push_back(t);
		end
		while (step_out.size() > 0)
			tokens_due.push_back(step_out.pop_front());
	endtask

	// would this word send the scanner into its error halt?
	function automatic bit breaks_syntax(input logic kind, input logic [7:0] c);
		case (lx_mode)
			SM_STR:  return kind == KIND_END;
			SM_DOT:  return kind == KIND_END || !(is_digit(c) || c == CH_DOT);
			SM_E:    return kind == KIND_END || !(is_digit(c) || c == CH_PLUS || c == CH_MINUS);
			SM_SIGN: return kind == KIND_END || !is_digit(c);
			default: return 1'b0;
		endcase
	endfunction

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------
	function automatic logic [7:0] rand_digit();
		logic [7:0] d;
		d = 8'($urandom_range(9));
		return "0" + d;
	endfunction

	function automatic logic [7:0] rand_letter();
		logic [7:0] d;
		d = 8'($urandom_range(25));
		return ($urandom_range(1) ? "a" : "A") + d;
	endfunction

	function automatic logic [7:0] rand_alnum();
		return ($urandom_range(2) == 0) ? rand_digit() : rand_letter();
	endfunction

	// One word through the handshake; bursts and gaps are decided here.
	task automatic send_item(input logic kind, input logic [7:0] b);
		lex_in_t w;
		int      gap;
		w.kind     = kind;
		w.byte_req = b;
		char_valid <= 1'b1;
		char_word  <= w;
		do @(posedge clk); while (char_stall);
		predict_tokens(w);
		words_sent++;
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0 && !steady) begin
			gap = $urandom_range(6);
			if (gap > 0) begin
				char_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(40, 1);
		end
	endtask

	// Random traffic must not halt the scanner: repair the syntax first.
	task automatic send_clean(input logic kind, input logic [7:0] b);
		if (breaks_syntax(kind, b))
			send_item(KIND_DATA, (lx_mode == SM_STR) ? CH_QUOTE : rand_digit());
		send_item(kind, b);
	endtask

	task automatic send_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			send_item(KIND_DATA, s[i]);
	endtask

	task automatic send_digits(input int n);
		int i;
		for (i = 0; i < n; i++)
			send_clean(KIND_DATA, rand_digit());
	endtask

	task automatic random_fragment();
		int         pick, n, i, k, m, flip_at;
		logic [7:0] c;
		pick = $urandom_range(99);
		if (pick < 20) begin
			case ($urandom_range(5))
				0:       c = CH_LBRACK;
				1:       c = CH_RBRACK;
				2:       c = CH_LBRACE;
				3:       c = CH_RBRACE;
				4:       c = CH_COMMA;
				default: c = CH_COLON;
			endcase
			send_clean(KIND_DATA, c);
		end else if (pick < 35) begin
			// string, now and then long enough to saturate the length
			n = ($urandom_range(15) == 0) ? $urandom_range(80, 60) : $urandom_range(8);
			send_clean(KIND_DATA, CH_QUOTE);
			for (i = 0; i < n; i++) begin
				c = 8'($urandom_range(255));
				if (c == CH_QUOTE || $urandom_range(9) == 0)
					c = CH_NL;
				send_clean(KIND_DATA, c);
			end
			send_clean(KIND_DATA, CH_QUOTE);
		end else if (pick < 55) begin
			send_digits(($urandom_range(20) == 0) ? $urandom_range(72, 60) : $urandom_range(4, 1));
			if ($urandom_range(2) == 0) begin
				send_clean(KIND_DATA, CH_DOT);
				if ($urandom_range(7) == 0)
					send_clean(KIND_DATA, CH_DOT);
				else
					send_digits($urandom_range(3, 1));
			end
			if ($urandom_range(2) == 0) begin
				send_clean(KIND_DATA, $urandom_range(1) ? CH_LC_E : CH_UC_E);
				case ($urandom_range(2))
					0:       send_clean(KIND_DATA, CH_PLUS);
					1:       send_clean(KIND_DATA, CH_MINUS);
					default: ;
				endcase
				send_digits($urandom_range(3, 1));
			end
		end else if (pick < 70) begin
			// keyword, exact or slightly mangled
			k = $urandom_range(5);
			n = (k == 2 || k == 3) ? 5 : 4;
			m = $urandom_range(5);
			if (m == 0)
				n = $urandom_range(n - 1, 1);
			flip_at = $urandom_range(n - 1);
			for (i = 0; i < n; i++) begin
				c = kw_char(k, i);
				if (m == 1 && i == flip_at)
					c = c ^ 8'h20;
				send_clean(KIND_DATA, c);
			end
			if (m == 2)
				send_clean(KIND_DATA, rand_alnum());
		end else if (pick < 78) begin
			n = ($urandom_range(20) == 0) ? $urandom_range(72, 60) : $urandom_range(6, 1);
			send_clean(KIND_DATA, rand_letter());
			for (i = 1; i < n; i++)
				send_clean(KIND_DATA, rand_alnum());
		end else if (pick < 90) begin
			case ($urandom_range(3))
				0:       send_clean(KIND_DATA, " ");
				1:       send_clean(KIND_DATA, 8'h09);
				2:       send_clean(KIND_DATA, CH_NL);
				default: send_clean(KIND_DATA, 8'h0d);
			endcase
		end else if (pick < 97)
			send_clean(KIND_DATA, 8'($urandom_range(255)));
		else
			send_clean(KIND_END, 8'($urandom_range(255)));
	endtask

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------
	task automatic test_punctuation();
		send_text("[]{},:\n[ ]");
		send_item(KIND_END, 8'h00);
	endtask

	// newline inside a string is part of it and leaves the line count alone
	task automatic test_strings();
		send_text("\"\" \"ab\ncd\" \"x\"\n:");
		send_item(KIND_END, 8'h00);
	endtask

	// "1.." gives the number without its dot and drops both dots
	task automatic test_numbers();
		send_text("12 3.5 7e9 4E+2 6.25e-1 0E-0 1..,");
		send_item(KIND_END, 8'h00);
	endtask

	task automatic test_keywords();
		send_text("true TRUE false FALSE null NULL True nul nullx t1,false:");
		send_item(KIND_END, 8'h00);
	endtask

	// a pending keyword or complete number is flushed ahead of the end token
	task automatic test_end_of_input();
		send_text("null");
		send_item(KIND_END, 8'h00);
		send_text("42");
		send_item(KIND_END, 8'hFF);
		send_text("1.5");
		send_item(KIND_END, 8'h00);
		send_text("2e7");
		send_item(KIND_END, 8'h00);
		send_text("abc");
		send_item(KIND_END, 8'h00);
		send_item(KIND_END, 8'h00);
	endtask

	// bytes above 127 are neither letters nor digits
	task automatic test_non_ascii();
		send_item(KIND_DATA, 8'h80);
		send_item(KIND_DATA, CH_LBRACK);
		send_item(KIND_DATA, 8'hFF);
		send_item(KIND_DATA, CH_QUOTE);
		send_item(KIND_DATA, 8'hE9);
		send_item(KIND_DATA, CH_QUOTE);
		send_text("7");
		send_item(KIND_DATA, 8'hB0);
		send_text("nul");
		send_item(KIND_DATA, 8'hFF);
		send_text("l");
		send_item(KIND_END, 8'h00);
	endtask

	task automatic test_long_tokens();
		int i;
		send_item(KIND_DATA, CH_QUOTE);
		for (i = 0; i < 80; i++)
			send_item(KIND_DATA, "a");
		send_item(KIND_DATA, CH_QUOTE);
		for (i = 0; i < 70; i++)
			send_item(KIND_DATA, rand_digit());
		send_text(",true");
		for (i = 0; i < 66; i++)
			send_item(KIND_DATA, "x");
		send_text(" 9.");
		for (i = 0; i < 66; i++)
			send_item(KIND_DATA, rand_digit());
		send_text("e+12345");
		send_item(KIND_END, 8'h00);
	endtask

	// receiver holds off while words keep coming: queue fills, input stalls
	task automatic test_hold_off();
		int i;
		steady           = 1'b1;
		hold_off_request = 300;
		for (i = 0; i < 40; i++)
			send_text("[1,");
		send_item(KIND_END, 8'h00);
		steady = 1'b0;
	endtask

	task automatic test_random();
		int start;
		start = words_sent;
		while (words_sent - start < RANDOM_WORDS)
			random_fragment();
		send_clean(KIND_END, 8'h00);
	endtask

	// only one error per run, since reset is never applied again
	task automatic test_error_halt();
		case ($urandom_range(6))
			0: send_text("1.x");
			1: send_text("2ex");
			2: send_text("3E+;");
			3: begin send_text("\"abc"); send_item(KIND_END, 8'h00); end
			4: begin send_text("4."); send_item(KIND_END, 8'h00); end
			5: begin send_text("5e"); send_item(KIND_END, 8'h00); end
			default: begin send_text("6e-"); send_item(KIND_END, 8'h00); end
		endcase
		// halted: everything from here on is swallowed
		send_text("[1 true");
		send_item(KIND_END, 8'h00);
	endtask

	// ---------------------------------------------------------------
	// Receiver: stall pattern of its own, plus the long hold-off
	// ---------------------------------------------------------------
	initial begin : tok_receiver
		int pct, left, hold_left;
		tok_stall <= 1'b0;
		pct       = 0;
		left      = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_off_request > 0) begin
				hold_left        = hold_off_request;
				hold_off_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				tok_stall <= 1'b1;
			end else begin
				if (left == 0) begin
					left = $urandom_range(200, 20);
					case ($urandom_range(4))
						0, 1:    pct = 0;
						2:       pct = 30;
						3:       pct = 60;
						default: pct = 90;
					endcase
				end
				left--;
				tok_stall <= ($urandom_range(99) < pct);
			end
		end
	end

	// ---------------------------------------------------------------
	// Token check against the oldest prediction
	// ---------------------------------------------------------------
	// fields shown as kind/line/length/last
	task automatic report_bad(input string why, input token_t want);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t %s: got %0d/%0d/%0d/%0b, expected %0d/%0d/%0d/%0b",
				$time, why, tok_word.token_kind, tok_word.line_number, tok_word.token_length,
				tok_word.last, want.token_kind, want.line_number, want.token_length, want.last);
	endtask

	always @(posedge clk) begin : token_check
		token_t want;
		if (arst_n && tok_valid && !tok_stall) begin
			if (tokens_due.size() == 0)
				report_bad("token with none due", '0);
			else begin
				want = tokens_due.pop_front();
				if (tok_word.token_kind !== want.token_kind ||
						tok_word.line_number !== want.line_number ||
						tok_word.token_length !== want.token_length ||
						tok_word.last !== want.last)
					report_bad("token mismatch", want);
			end
		end
	end

	// ---------------------------------------------------------------
	// Sequence
	// ---------------------------------------------------------------
	initial begin
		arst_n     <= 1'b0;
		char_valid <= 1'b0;
		char_word  <= '0;
		clear_lexer();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_punctuation();
		test_strings();
		test_numbers();
		test_keywords();
		test_end_of_input();
		test_non_ascii();
		test_long_tokens();
		test_hold_off();
		test_random();
		test_error_halt();

		char_valid <= 1'b0;
		while (tokens_due.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && tokens_due.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
